@@ design/snu_pkg.sv @@
// Shared types, constants and fixed-point helpers for the spiking neuron update engine.
// No dependencies; snu_mul, snu_core and the top level import this package.
package snu_pkg;

    // Widths of the shared multiplier, of intermediate sums and of the config index.
    localparam int MUL_A_W = 48;
    localparam int MUL_B_W = 33;
    localparam int MUL_P_W = 81;
    localparam int WIDE_W  = 66;
    localparam int CHUNK_W = 16;
    localparam int CFG_IDX_W = 3;

    // Operation and model codes of an input item.
    localparam logic [1:0] OP_STIM    = 2'd0;
    localparam logic [1:0] OP_UPDATE  = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;
    localparam logic [1:0] MODEL_ALIF = 2'd1;
    localparam logic [1:0] MODEL_IZH  = 2'd2;

    // Q16.16 constants.
    localparam logic [16:0]        ONE_Q = 17'd65536;
    localparam logic signed [32:0] K_004 = 33'sd2621;
    localparam logic signed [32:0] K_099 = 33'sd64881;
    localparam logic signed [WIDE_W-1:0] K_140 = WIDE_W'(140 * 65536);
    localparam logic signed [31:0] K_30  = 32'sd1966080;

    typedef enum logic [2:0] {
        REG_TIME_STEP,
        REG_FIRE_THRESHOLD,
        REG_LEAK_RATE,
        REG_RESET_LEVEL,
        REG_IZH_A,
        REG_IZH_B,
        REG_IZH_C,
        REG_IZH_D
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_ISSUE,
        ST_WAIT,
        ST_FINISH
    } state_t;

    typedef enum logic [3:0] {
        STEP_ADAPT,
        STEP_LEAK,
        STEP_LIF_DT,
        STEP_VV,
        STEP_Q,
        STEP_BV,
        STEP_AT,
        STEP_V_DT,
        STEP_U_DT
    } step_t;

    // One entry of the neuron table.
    typedef struct packed {
        logic signed [31:0] potential;
        logic signed [31:0] recovery;
        logic signed [31:0] adaptation;
        logic signed [31:0] input_sum;
        logic [31:0]        last_tick;
        logic               has_spiked;
    } nrn_t;

    // Configuration as seen by the core; dt is already clamped to one.
    typedef struct packed {
        logic [16:0]        dt;
        logic signed [31:0] thr;
        logic [30:0]        leak;
        logic signed [31:0] rst_level;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] d;
    } cfg_t;

    typedef struct packed {
        logic                       start;
        logic signed [MUL_A_W-1:0]  a;
        logic signed [MUL_B_W-1:0]  b;
    } mul_req_t;

    typedef struct packed {
        logic                       busy;
        logic                       done;
        logic signed [MUL_P_W-1:0]  product;
    } mul_rsp_t;

    // Sign extension of a Q16.16 value to the wide sum width.
    function automatic logic signed [WIDE_W-1:0] wx(input logic signed [31:0] x);
        return {{(WIDE_W-32){x[31]}}, x};
    endfunction

    // Product shifted right by 16, rounding toward minus infinity.
    function automatic logic signed [WIDE_W-1:0] fl16(input logic signed [MUL_P_W-1:0] p);
        return {p[MUL_P_W-1], p[MUL_P_W-1:16]};
    endfunction

    // Saturation of a wide sum to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] x);
        logic signed [31:0] r;
        if (&x[WIDE_W-1:31] || ~|x[WIDE_W-1:31])
        begin
            r = x[31:0];
        end
        else if (x[WIDE_W-1])
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = 32'sh7fff_ffff;
        end
        return r;
    endfunction

endpackage

@@ design/snu_in_if.sv @@
// Input channel of the spiking neuron update engine: valid/ready plus the item fields.
// No dependencies.
interface snu_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic [9:0]         neuron_index;
    logic [1:0]         neuron_model;
    logic signed [31:0] stimulus;

    modport source (output valid, output op, output neuron_index, output neuron_model,
                    output stimulus, input ready);
    modport sink (input valid, input op, input neuron_index, input neuron_model,
                  input stimulus, output ready);
endinterface

@@ design/snu_out_if.sv @@
// Result channel of the spiking neuron update engine: valid/ready plus the result fields.
// No dependencies.
interface snu_out_if;
    logic               valid;
    logic               ready;
    logic [9:0]         neuron_index_out;
    logic               spiked;
    logic signed [31:0] potential_out;
    logic signed [31:0] recovery_out;

    modport source (output valid, output neuron_index_out, output spiked,
                    output potential_out, output recovery_out, input ready);
    modport sink (input valid, input neuron_index_out, input spiked,
                  input potential_out, input recovery_out, output ready);
endinterface

@@ design/snu_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module snu_ram #(
    parameter int WIDTH = 161,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/snu_mul.sv @@
// Shared sequential multiplier: 48-bit signed by 33-bit signed, 16 bits of A a cycle.
// Depends on snu_pkg.
module snu_mul (
    input  logic             clk,
    input  logic             rst_n,
    input  snu_pkg::mul_req_t req,
    output snu_pkg::mul_rsp_t rsp
);
    import snu_pkg::*;

    localparam int CHUNKS = MUL_A_W / CHUNK_W;
    localparam int CW     = $clog2(CHUNKS);

    logic signed [MUL_A_W-1:0] a_reg;
    logic signed [MUL_B_W-1:0] b_reg;
    logic signed [MUL_P_W-1:0] acc_reg;
    logic signed [MUL_P_W-1:0] acc_next;
    logic [CW-1:0]             cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic signed [CHUNK_W:0]   chunk;
    logic signed [CHUNK_W+MUL_B_W:0] pp;

    // Current digit of A, most significant (signed) digit first.
    always_comb
    begin
        if (cnt_reg == CW'(CHUNKS - 1))
        begin
            chunk = {a_reg[MUL_A_W-1], a_reg[MUL_A_W-1 -: CHUNK_W]};
        end
        else
        begin
            chunk = {1'b0, a_reg[cnt_reg * CHUNK_W +: CHUNK_W]};
        end
    end

    // One partial product and a shifted accumulate per cycle.
    assign pp       = chunk * b_reg;
    assign acc_next = (acc_reg <<< CHUNK_W) + MUL_P_W'(pp);

    // Operand capture and digit counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(CHUNKS - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign rsp.busy    = busy_reg;
    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

@@ design/snu_core.sv @@
// Sequencer and datapath of the neuron update engine: table RAM, tick counter,
// multiply schedule per model and the result register. Depends on snu_pkg,
// snu_in_if, snu_out_if, snu_ram and snu_mul.
module snu_core #(
    parameter int NUM_NEURONS      = 1024,
    parameter int REFRACTORY_TICKS = 2,
    parameter int ADAPT_INCREMENT  = 66
) (
    input  logic          clk,
    input  logic          rst_n,
    snu_in_if.sink        in_ch,
    snu_out_if.source     out_ch,
    input  snu_pkg::cfg_t cfg
);
    import snu_pkg::*;

    localparam int AW = $clog2(NUM_NEURONS);

    state_t state_reg, state_next;
    step_t  step_reg, step_next;
    logic   step_last;

    logic [AW-1:0]      clr_reg;
    logic [31:0]        tick_reg;
    logic [1:0]         op_reg;
    logic [9:0]         idx_reg;
    logic [1:0]         model_reg;
    logic signed [31:0] stim_reg;
    nrn_t               ent_reg;
    logic               in_win_reg;
    logic signed [31:0] w_reg;
    logic signed [31:0] cur_reg;
    logic signed [MUL_A_W-1:0] dv_reg;
    logic signed [MUL_A_W-1:0] q_reg;
    logic signed [MUL_A_W-1:0] du_reg;
    logic signed [31:0] t_reg;
    logic signed [31:0] nv_reg;
    logic signed [31:0] nu_reg;

    logic               out_valid_reg;
    logic [9:0]         out_idx_reg;
    logic               out_spiked_reg;
    logic signed [31:0] out_pot_reg;
    logic signed [31:0] out_rec_reg;

    logic       accept;
    logic       in_range;
    logic       go;
    logic       out_free;
    logic       fin_load;
    logic       ram_we;
    logic [AW-1:0] ram_waddr;
    nrn_t       ram_wdata;
    nrn_t       ram_rdata;
    logic [31:0] since_spike;

    mul_req_t mul_req;
    mul_rsp_t mul_rsp;

    logic signed [WIDE_W-1:0]  ph;
    logic signed [WIDE_W-1:0]  v_w;
    logic signed [WIDE_W-1:0]  u_w;
    logic signed [MUL_A_W-1:0] v_a;
    logic signed [MUL_B_W-1:0] dt_b;
    logic signed [31:0]        w_new;

    logic               is_izh;
    logic               is_alif;
    logic               spike;
    logic signed [31:0] fin_pot;
    logic signed [31:0] fin_rec;
    nrn_t               fin_ent;

    // Input handshake: one item at a time, none during the clearing pass.
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign in_range    = 32'(in_ch.neuron_index) < 32'(NUM_NEURONS);
    assign go          = accept && in_range && (in_ch.op == OP_STIM || in_ch.op == OP_UPDATE);
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign fin_load    = (state_reg == ST_FINISH) && out_free;

    // Neuron table.
    snu_ram #(
        .WIDTH ($bits(nrn_t)),
        .DEPTH (NUM_NEURONS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (AW'(in_ch.neuron_index)),
        .rdata (ram_rdata)
    );

    snu_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    // Common operand forms.
    assign ph   = fl16(mul_rsp.product);
    assign v_w  = wx(ent_reg.potential);
    assign u_w  = wx(ent_reg.recovery);
    assign v_a  = MUL_A_W'(v_w);
    assign dt_b = {{(MUL_B_W-17){1'b0}}, cfg.dt};
    assign w_new = in_win_reg ? sat32(wx(ent_reg.adaptation) + ph) : ph[31:0];
    assign since_spike = tick_reg - ram_rdata.last_tick;

    // Multiplier operands for each step of the schedule.
    always_comb
    begin
        mul_req.start = (state_reg == ST_ISSUE);
        mul_req.a     = v_a;
        mul_req.b     = dt_b;
        unique case (step_reg)
            STEP_ADAPT:
            begin
                if (in_win_reg)
                begin
                    mul_req.a = {{(MUL_A_W-17){1'b0}}, cfg.dt};
                    mul_req.b = MUL_B_W'(ADAPT_INCREMENT);
                end
                else
                begin
                    mul_req.a = MUL_A_W'(wx(ent_reg.adaptation));
                    mul_req.b = K_099;
                end
            end
            STEP_LEAK:
            begin
                mul_req.b = {2'b00, cfg.leak};
            end
            STEP_LIF_DT, STEP_V_DT:
            begin
                mul_req.a = dv_reg;
            end
            STEP_VV:
            begin
                mul_req.b = {ent_reg.potential[31], ent_reg.potential};
            end
            STEP_Q:
            begin
                mul_req.a = q_reg;
                mul_req.b = K_004;
            end
            STEP_BV:
            begin
                mul_req.b = {cfg.b[31], cfg.b};
            end
            STEP_AT:
            begin
                mul_req.a = MUL_A_W'(wx(t_reg));
                mul_req.b = {cfg.a[31], cfg.a};
            end
            STEP_U_DT:
            begin
                mul_req.a = du_reg;
            end
            default:
            begin
                mul_req.a = v_a;
            end
        endcase
    end

    // Successor of each step; the last step of a model leads to write-back.
    always_comb
    begin
        step_last = 1'b0;
        step_next = step_reg;
        unique case (step_reg)
            STEP_ADAPT:  step_next = STEP_LEAK;
            STEP_LEAK:   step_next = STEP_LIF_DT;
            STEP_LIF_DT: step_last = 1'b1;
            STEP_VV:     step_next = STEP_Q;
            STEP_Q:      step_next = STEP_BV;
            STEP_BV:     step_next = STEP_AT;
            STEP_AT:     step_next = STEP_V_DT;
            STEP_V_DT:   step_next = STEP_U_DT;
            STEP_U_DT:   step_last = 1'b1;
            default:     step_last = 1'b1;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == AW'(NUM_NEURONS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (go)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = (op_reg == OP_STIM) ? ST_IDLE : ST_ISSUE;
            end
            ST_ISSUE:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    state_next = step_last ? ST_FINISH : ST_ISSUE;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Final values of an update.
    assign is_izh  = (model_reg == MODEL_IZH);
    assign is_alif = (model_reg == MODEL_ALIF);
    assign spike   = is_izh ? (nv_reg >= K_30) : (nv_reg >= cfg.thr);
    assign fin_pot = spike ? (is_izh ? cfg.c : cfg.rst_level) : nv_reg;

    always_comb
    begin
        if (!is_izh)
        begin
            fin_rec = ent_reg.recovery;
        end
        else if (spike)
        begin
            fin_rec = sat32(wx(nu_reg) + wx(cfg.d));
        end
        else
        begin
            fin_rec = nu_reg;
        end
    end

    always_comb
    begin
        fin_ent            = ent_reg;
        fin_ent.potential  = fin_pot;
        fin_ent.recovery   = fin_rec;
        fin_ent.adaptation = is_alif ? w_reg : ent_reg.adaptation;
        fin_ent.input_sum  = '0;
        fin_ent.last_tick  = spike ? tick_reg : ent_reg.last_tick;
        fin_ent.has_spiked = ent_reg.has_spiked || spike;
    end

    // Table write port: clearing pass, stimulus accumulation or write-back.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = AW'(idx_reg);
        ram_wdata = fin_ent;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
            end
            ST_FETCH:
            begin
                ram_wdata           = ram_rdata;
                ram_wdata.input_sum = sat32(wx(ram_rdata.input_sum) + wx(stim_reg));
                ram_we              = (op_reg == OP_STIM);
            end
            ST_FINISH:
            begin
                ram_we = out_free;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            step_reg      <= STEP_LEAK;
            clr_reg       <= '0;
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (accept && in_ch.op == OP_TICK)
            begin
                tick_reg <= tick_reg + 1'b1;
            end
            if (state_reg == ST_FETCH)
            begin
                unique case (model_reg)
                    MODEL_ALIF: step_reg <= STEP_ADAPT;
                    MODEL_IZH:  step_reg <= STEP_VV;
                    default:    step_reg <= STEP_LEAK;
                endcase
            end
            else if (state_reg == ST_WAIT && mul_rsp.done)
            begin
                step_reg <= step_next;
            end
            if (fin_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item capture and entry read.
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            op_reg    <= in_ch.op;
            idx_reg   <= in_ch.neuron_index;
            model_reg <= in_ch.neuron_model;
            stim_reg  <= in_ch.stimulus;
        end
        if (state_reg == ST_FETCH)
        begin
            ent_reg    <= ram_rdata;
            cur_reg    <= ram_rdata.input_sum;
            w_reg      <= ram_rdata.adaptation;
            in_win_reg <= ram_rdata.has_spiked && (since_spike < 32'(REFRACTORY_TICKS));
        end
        else if (state_reg == ST_WAIT && mul_rsp.done)
        begin
            // Fold each product into the model's intermediate values.
            unique case (step_reg)
                STEP_ADAPT:
                begin
                    w_reg   <= w_new;
                    cur_reg <= sat32(wx(cur_reg) - wx(w_new));
                end
                STEP_LEAK:   dv_reg <= MUL_A_W'(wx(cur_reg) - ph);
                STEP_LIF_DT: nv_reg <= sat32(v_w + ph);
                STEP_VV:     q_reg  <= ph[MUL_A_W-1:0];
                STEP_Q:
                begin
                    dv_reg <= MUL_A_W'(ph + (v_w <<< 2) + v_w + K_140 - u_w + wx(cur_reg));
                end
                STEP_BV:     t_reg  <= sat32(ph - u_w);
                STEP_AT:     du_reg <= ph[MUL_A_W-1:0];
                STEP_V_DT:   nv_reg <= sat32(v_w + ph);
                STEP_U_DT:   nu_reg <= sat32(u_w + ph);
                default:     nu_reg <= nu_reg;
            endcase
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (fin_load)
        begin
            out_idx_reg    <= idx_reg;
            out_spiked_reg <= spike;
            out_pot_reg    <= fin_pot;
            out_rec_reg    <= fin_rec;
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.neuron_index_out = out_idx_reg;
    assign out_ch.spiked           = out_spiked_reg;
    assign out_ch.potential_out    = out_pot_reg;
    assign out_ch.recovery_out     = out_rec_reg;

    // The multiplier is only started when it is free.
    assert property (@(posedge clk) disable iff (!rst_n) mul_req.start |-> !mul_rsp.busy)
        else $error("multiplier started while busy");

    // Every result comes with the write-back of its neuron.
    assert property (@(posedge clk) disable iff (!rst_n) fin_load |-> ram_we)
        else $error("result loaded without table write-back");

    // The tick moves only on an accepted tick item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (tick_reg != $past(tick_reg)) |-> $past(accept && in_ch.op == OP_TICK))
        else $error("tick changed without a tick transfer");

    // No multiply is left running once the sequencer is back to idle.
    assert property (@(posedge clk) disable iff (!rst_n) (state_reg == ST_IDLE) |-> !mul_rsp.busy)
        else $error("multiplier busy while idle");

    // Nothing is reported during the clearing pass.
    assert property (@(posedge clk) disable iff (!rst_n) (state_reg == ST_CLEAR) |-> !out_valid_reg)
        else $error("result valid during clearing pass");

endmodule

@@ design/spiking_neuron_update_top.sv @@
// Top level of the spiking neuron update engine: configuration registers and the core.
// Depends on snu_pkg, snu_in_if, snu_out_if and snu_core.
//
//   Channel  Dir  Handshake            Carries
//   in_ch    in   valid/ready          op, neuron_index, neuron_model, stimulus
//   out_ch   out  valid/ready          neuron_index_out, spiked, potential_out, recovery_out
//   cfg      in   cfg_we (no wait)     cfg_index, cfg_data
//
// A stimulate item reads and writes back its entry, a tick only counts, and an update
// runs a multiply schedule on the shared 48x33 multiplier: two multiplies for LIF,
// three for adaptive LIF, six for Izhikevich, each made of an issue, three 16-bit digits
// and the taking of the product. After reset a clearing pass zeroes the table before the
// first item is taken. A result waits in an output register; the next item is taken
// meanwhile, and only the write-back and result of an update wait for the register.
module spiking_neuron_update_top #(
    parameter int NUM_NEURONS      = 1024,
    parameter int REFRACTORY_TICKS = 2,
    parameter int ADAPT_INCREMENT  = 66
) (
    input  logic                         clk,
    input  logic                         rst_n,
    snu_in_if.sink                       in_ch,
    snu_out_if.source                    out_ch,
    input  logic                         cfg_we,
    input  logic [snu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                  cfg_data
);
    import snu_pkg::*;

    logic [16:0]        time_step_reg;
    logic signed [31:0] fire_threshold_reg;
    logic [30:0]        leak_rate_reg;
    logic signed [31:0] reset_level_reg;
    logic signed [31:0] izh_a_reg;
    logic signed [31:0] izh_b_reg;
    logic signed [31:0] izh_c_reg;
    logic signed [31:0] izh_d_reg;
    cfg_t               cfg;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg      <= 17'd66;
            fire_threshold_reg <= 32'sd65536;
            leak_rate_reg      <= 31'd65536;
            reset_level_reg    <= 32'sd0;
            izh_a_reg          <= 32'sd1311;
            izh_b_reg          <= 32'sd13107;
            izh_c_reg          <= -32'sd4259840;
            izh_d_reg          <= 32'sd524288;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TIME_STEP:      time_step_reg      <= cfg_data[16:0];
                REG_FIRE_THRESHOLD: fire_threshold_reg <= cfg_data;
                REG_LEAK_RATE:      leak_rate_reg      <= cfg_data[30:0];
                REG_RESET_LEVEL:    reset_level_reg    <= cfg_data;
                REG_IZH_A:          izh_a_reg          <= cfg_data;
                REG_IZH_B:          izh_b_reg          <= cfg_data;
                REG_IZH_C:          izh_c_reg          <= cfg_data;
                REG_IZH_D:          izh_d_reg          <= cfg_data;
                default:            izh_d_reg          <= izh_d_reg;
            endcase
        end
    end

    // Time steps above one are used as one.
    always_comb
    begin
        cfg.dt        = (time_step_reg > ONE_Q) ? ONE_Q : time_step_reg;
        cfg.thr       = fire_threshold_reg;
        cfg.leak      = leak_rate_reg;
        cfg.rst_level = reset_level_reg;
        cfg.a         = izh_a_reg;
        cfg.b         = izh_b_reg;
        cfg.c         = izh_c_reg;
        cfg.d         = izh_d_reg;
    end

    snu_core #(
        .NUM_NEURONS      (NUM_NEURONS),
        .REFRACTORY_TICKS (REFRACTORY_TICKS),
        .ADAPT_INCREMENT  (ADAPT_INCREMENT)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

endmodule

@@ test/tb_spiking_neuron_update_top.sv @@
// Testbench for spiking_neuron_update_top: directed and random items on the input channel,
// checked against a built-in predictor of the neuron table. Depends on snu_pkg,
// snu_in_if, snu_out_if and the design top level.
module tb_spiking_neuron_update_top;
    import snu_pkg::*;

    localparam int NUM_NEURONS      = 1024;
    localparam int REFRACTORY_TICKS = 2;
    localparam int ADAPT_INCREMENT  = 66;
    localparam int SETTLE_CYCLES    = 60;
    localparam int LONG_HOLD_CYCLES = 400;

    typedef struct {
        logic [9:0]         idx;
        logic               spk;
        logic signed [31:0] v;
        logic signed [31:0] u;
    } neuron_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;

    snu_in_if  in_ch();
    snu_out_if out_ch();

    spiking_neuron_update_top #(
        .NUM_NEURONS(NUM_NEURONS),
        .REFRACTORY_TICKS(REFRACTORY_TICKS),
        .ADAPT_INCREMENT(ADAPT_INCREMENT)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Predicted neuron table, tick counter and configuration.
    int          pot_tbl [NUM_NEURONS];
    int          rec_tbl [NUM_NEURONS];
    int          adapt_tbl [NUM_NEURONS];
    int          sum_tbl [NUM_NEURONS];
    int unsigned last_tick_tbl [NUM_NEURONS];
    bit          fired_tbl [NUM_NEURONS];
    int unsigned tick_now;
    int unsigned dt_reg;
    int          thr_reg;
    int unsigned leak_reg;
    int          rst_lvl_reg;
    int          a_reg, b_reg, c_reg, d_reg;

    neuron_result_t pending_results[$];
    int  mismatches;
    int  items_sent;
    int  results_seen;
    int  spikes_seen;
    bit  calm;
    bit  hold_req;

    // Clock.
    initial
    begin
        clk = 1'b0;
    end
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint floor_q16(input longint x);
        return x >>> 16;
    endfunction

    function automatic int clamp32(input longint x);
        if (x > 64'sd2147483647)
        begin
            return 32'sh7fff_ffff;
        end
        else if (x < -64'sd2147483648)
        begin
            return 32'sh8000_0000;
        end
        return int'(x);
    endfunction

    function automatic longint step_dt();
        return (dt_reg > 65536) ? 64'sd65536 : longint'(dt_reg);
    endfunction

    // Leaky integrate-and-fire step; returns the spike flag.
    function automatic bit lif_step(input int n, input longint cur);
        longint v;
        longint dv;
        int     nv;
        v  = pot_tbl[n];
        dv = -floor_q16(longint'(leak_reg) * v) + cur;
        nv = clamp32(v + floor_q16(dv * step_dt()));
        if (nv >= thr_reg)
        begin
            pot_tbl[n] = rst_lvl_reg;
            return 1'b1;
        end
        pot_tbl[n] = nv;
        return 1'b0;
    endfunction

    function automatic bit adaptive_step(input int n, input longint cur);
        longint w;
        int unsigned since;
        since = tick_now - last_tick_tbl[n];
        w = adapt_tbl[n];
        if (fired_tbl[n] && since < REFRACTORY_TICKS)
        begin
            w = clamp32(w + floor_q16(longint'(ADAPT_INCREMENT) * step_dt()));
        end
        else
        begin
            w = floor_q16(w * 64'sd64881);
        end
        adapt_tbl[n] = int'(w);
        return lif_step(n, clamp32(cur - w));
    endfunction

    function automatic bit izhikevich_step(input int n, input longint cur);
        longint v, u, q, dv, t, du;
        int     nv, nu;
        v  = pot_tbl[n];
        u  = rec_tbl[n];
        q  = floor_q16(v * v);
        dv = floor_q16(q * 64'sd2621) + 5 * v + 64'sd140 * 65536 - u + cur;
        t  = clamp32(floor_q16(longint'(b_reg) * v) - u);
        du = floor_q16(longint'(a_reg) * t);
        nv = clamp32(v + floor_q16(dv * step_dt()));
        nu = clamp32(u + floor_q16(du * step_dt()));
        if (nv >= 30 * 65536)
        begin
            pot_tbl[n] = c_reg;
            rec_tbl[n] = clamp32(longint'(nu) + longint'(d_reg));
            return 1'b1;
        end
        pot_tbl[n] = nv;
        rec_tbl[n] = nu;
        return 1'b0;
    endfunction

    // Applies one accepted item to the predicted table and queues any result.
    function automatic void apply_item(input logic [1:0] op, input logic [9:0] idx,
                                       input logic [1:0] model, input int stim);
        int n;
        longint cur;
        bit sp;
        neuron_result_t r;
        n = idx;
        if (op == OP_TICK)
        begin
            tick_now = tick_now + 1;
        end
        else if (op == OP_STIM)
        begin
            sum_tbl[n] = clamp32(longint'(sum_tbl[n]) + longint'(stim));
        end
        else if (op == OP_UPDATE)
        begin
            cur = sum_tbl[n];
            sum_tbl[n] = 0;
            if (model == MODEL_ALIF)
            begin
                sp = adaptive_step(n, cur);
            end
            else if (model == MODEL_IZH)
            begin
                sp = izhikevich_step(n, cur);
            end
            else
            begin
                sp = lif_step(n, cur);
            end
            if (sp)
            begin
                last_tick_tbl[n] = tick_now;
                fired_tbl[n] = 1'b1;
            end
            r.idx = idx;
            r.spk = sp;
            r.v   = pot_tbl[n];
            r.u   = rec_tbl[n];
            pending_results = {pending_results, r};
        end
    endfunction

    // Sends one item from a falling edge; returns at the falling edge after it is taken.
    task automatic send_item(input logic [1:0] op, input logic [9:0] idx,
                             input logic [1:0] model, input int stim);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        in_ch.valid        = 1'b1;
        in_ch.op           = op;
        in_ch.neuron_index = idx;
        in_ch.neuron_model = model;
        in_ch.stimulus     = stim;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        apply_item(op, idx, model, stim);
        items_sent++;
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    // Waits until every expected result has arrived and the block has settled.
    task automatic drain();
        in_ch.valid = 1'b0;
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [31:0] data);
        cfg_we    = 1'b1;
        cfg_index = r;
        cfg_data  = data;
        @(negedge clk);
        cfg_we = 1'b0;
        case (r)
            REG_TIME_STEP:      dt_reg = data[16:0];
            REG_FIRE_THRESHOLD: thr_reg = data;
            REG_LEAK_RATE:      leak_reg = data[30:0];
            REG_RESET_LEVEL:    rst_lvl_reg = data;
            REG_IZH_A:          a_reg = data;
            REG_IZH_B:          b_reg = data;
            REG_IZH_C:          c_reg = data;
            default:            d_reg = data;
        endcase
    endtask

    // One random item, mostly aimed at a handful of neurons so that currents build up.
    task automatic send_random_item();
        logic [1:0] op;
        logic [9:0] idx;
        int stim;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 42)
        begin
            op = OP_STIM;
        end
        else if (pick < 82)
        begin
            op = OP_UPDATE;
        end
        else if (pick < 96)
        begin
            op = OP_TICK;
        end
        else
        begin
            op = 2'd3;
        end
        idx = ($urandom_range(0, 4) == 0) ? 10'($urandom) : 10'($urandom_range(0, 7));
        case ($urandom_range(0, 3))
            0:       stim = $urandom;
            1:       stim = int'($urandom_range(0, 1 << 22)) - (1 << 21);
            default: stim = int'($urandom_range(0, 1 << 18));
        endcase
        send_item(op, idx, 2'($urandom), stim);
    endtask

    task automatic test_directed();
        // Accumulator saturation at both ends, then an update of each model.
        send_item(OP_STIM, 10'd1, 2'd0, 32'sh7fff_ffff);
        send_item(OP_STIM, 10'd1, 2'd0, 32'sh7fff_ffff);
        send_item(OP_UPDATE, 10'd1, 2'd0, 0);
        send_item(OP_STIM, 10'd2, 2'd0, 32'sh8000_0000);
        send_item(OP_STIM, 10'd2, 2'd0, 32'sh8000_0000);
        send_item(OP_UPDATE, 10'd2, 2'd1, 0);
        send_item(OP_STIM, 10'd1023, 2'd0, 32'sh0010_0000);
        send_item(OP_UPDATE, 10'd1023, MODEL_IZH, 0);
        // Unused model code runs as LIF; unused op code does nothing.
        send_item(OP_STIM, 10'd3, 2'd0, 32'sh0002_0000);
        send_item(OP_UPDATE, 10'd3, 2'd3, 0);
        send_item(2'd3, 10'd3, 2'd3, 32'sh7fff_ffff);
        send_item(OP_UPDATE, 10'd3, 2'd3, 0);
        send_item(OP_TICK, 10'd0, 2'd0, 0);
        send_item(OP_UPDATE, 10'd0, 2'd0, 0);
        drain();
        // Full step with a low threshold so adaptive neurons fire inside the window.
        write_reg(REG_TIME_STEP, 32'd65536);
        write_reg(REG_FIRE_THRESHOLD, 32'sh0000_1000);
        for (int k = 0; k < 4; k++)
        begin
            send_item(OP_STIM, 10'd4, 2'd0, 32'sh0004_0000);
            send_item(OP_UPDATE, 10'd4, MODEL_ALIF, 0);
            send_item(OP_TICK, 10'd0, 2'd0, 0);
        end
        drain();
    endtask

    task automatic test_config_extremes();
        // Clamped then zero step, with extreme leak, threshold and Izhikevich settings.
        write_reg(REG_TIME_STEP, 32'h0001_ffff);
        write_reg(REG_LEAK_RATE, 32'h7fff_ffff);
        write_reg(REG_FIRE_THRESHOLD, 32'sh8000_0000);
        write_reg(REG_RESET_LEVEL, 32'sh7fff_ffff);
        write_reg(REG_IZH_A, 32'sh7fff_ffff);
        write_reg(REG_IZH_B, 32'sh8000_0000);
        write_reg(REG_IZH_C, 32'sh8000_0000);
        write_reg(REG_IZH_D, 32'sh7fff_ffff);
        repeat (120) send_random_item();
        drain();
        write_reg(REG_LEAK_RATE, 32'd0);
        write_reg(REG_FIRE_THRESHOLD, 32'sh7fff_ffff);
        write_reg(REG_RESET_LEVEL, 32'sh8000_0000);
        write_reg(REG_IZH_A, 32'sh8000_0000);
        write_reg(REG_IZH_B, 32'sh7fff_ffff);
        write_reg(REG_IZH_C, 32'sh7fff_ffff);
        write_reg(REG_IZH_D, 32'sh8000_0000);
        write_reg(REG_TIME_STEP, 32'd0);
        repeat (120) send_random_item();
        drain();
    endtask

    task automatic test_random_phases();
        // Lively settings: full step, threshold near one, default Izhikevich.
        write_reg(REG_TIME_STEP, 32'd65536);
        write_reg(REG_LEAK_RATE, 32'd6554);
        write_reg(REG_FIRE_THRESHOLD, 32'sh0001_0000);
        write_reg(REG_RESET_LEVEL, 32'd0);
        write_reg(REG_IZH_A, 32'd1311);
        write_reg(REG_IZH_B, 32'd13107);
        write_reg(REG_IZH_C, 32'hffbf_0000);
        write_reg(REG_IZH_D, 32'd524288);
        repeat (400) send_random_item();
        drain();
        for (int ph = 0; ph < 3; ph++)
        begin
            write_reg(REG_TIME_STEP, 32'($urandom_range(0, 70000)));
            write_reg(REG_FIRE_THRESHOLD, 32'($urandom_range(0, 1 << 20)));
            write_reg(REG_LEAK_RATE, 32'($urandom_range(0, 1 << 17)));
            write_reg(REG_RESET_LEVEL, 32'(int'($urandom_range(0, 1 << 18)) - (1 << 17)));
            repeat (200) send_random_item();
            drain();
        end
    endtask

    task automatic test_backpressure();
        // The receiver holds off for a long stretch while items keep coming.
        hold_req = 1'b1;
        repeat (150) send_random_item();
        drain();
    endtask

    task automatic test_calm_tail();
        calm = 1'b1;
        repeat (150) send_random_item();
    endtask

    // Result receiver: random stall bursts, plus one long hold-off on request.
    initial
    begin
        int held;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ch.ready = 1'b0;
                held = 0;
                while (held < LONG_HOLD_CYCLES)
                begin
                    @(negedge clk);
                    held++;
                end
                hold_req = 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                out_ch.ready = 1'b0;
                repeat ($urandom_range(1, 17) - 1) @(negedge clk);
            end
            else
            begin
                out_ch.ready = 1'b1;
            end
        end
    end

    // Result checker: each transfer against the oldest prediction.
    always @(posedge clk)
    begin
        neuron_result_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            results_seen++;
            if (out_ch.spiked)
            begin
                spikes_seen++;
            end
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("Unexpected result for neuron %0d", out_ch.neuron_index_out);
                end
            end
            else
            begin
                e = pending_results.pop_front();
                if (out_ch.neuron_index_out !== e.idx || out_ch.spiked !== e.spk ||
                    out_ch.potential_out !== e.v || out_ch.recovery_out !== e.u)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("Mismatch: expected idx %0d spk %0d v %0d u %0d", e.idx,
                                 e.spk, e.v, e.u);
                        $display("          got      idx %0d spk %0d v %0d u %0d",
                                 out_ch.neuron_index_out, out_ch.spiked,
                                 out_ch.potential_out, out_ch.recovery_out);
                    end
                end
            end
        end
    end

    // Overall limit on the run.
    initial
    begin
        #8000000;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("*** FAILED ***");
        $finish;
    end

    // Main sequence.
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.op = OP_STIM;
        in_ch.neuron_index = '0;
        in_ch.neuron_model = '0;
        in_ch.stimulus = '0;
        calm = 1'b0;
        hold_req = 1'b0;
        mismatches = 0;
        items_sent = 0;
        results_seen = 0;
        spikes_seen = 0;
        tick_now = 0;
        dt_reg = 66;
        thr_reg = 65536;
        leak_reg = 65536;
        rst_lvl_reg = 0;
        a_reg = 1311;
        b_reg = 13107;
        c_reg = -4259840;
        d_reg = 524288;
        for (int i = 0; i < NUM_NEURONS; i++)
        begin
            pot_tbl[i] = 0;
            rec_tbl[i] = 0;
            adapt_tbl[i] = 0;
            sum_tbl[i] = 0;
            last_tick_tbl[i] = 0;
            fired_tbl[i] = 1'b0;
        end
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_config_extremes();
        test_random_phases();
        test_backpressure();
        test_calm_tail();
        drain();
        $display("Sent %0d items over several register settings; checked %0d results, %0d spikes.",
                 items_sent, results_seen, spikes_seen);
        if (mismatches == 0 && pending_results.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
